### rtl/rgb2hsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsl_pkg;

    // Field widths of the pixel and result words.
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;
    localparam int SAT_W  = 13;
    localparam int SUM_W  = 9;

    // Default precision of the hue and saturation fractions.
    localparam int HUE_FRACTION_BITS_DEF = 6;
    localparam int SAT_FRACTION_BITS_DEF = 12;

    // Hue sector arithmetic: 60 degrees per sector, six sectors.
    localparam int DEG_PER_SECTOR    = 60;
    localparam int SECTOR_COUNT      = 6;
    localparam int GREEN_SECTOR_BASE = 2;
    localparam int BLUE_SECTOR_BASE  = 4;

    // Component and lightness ranges.
    localparam int CHAN_MAX = 255;
    localparam int SUM_MAX  = 510;

    // Sector position (0 .. 6*chroma) and its value in degrees times chroma.
    localparam int M_W = 11;
    localparam int T_W = 17;
    // Whole degrees of hue, 0 .. 359.
    localparam int Q_W = 9;

    // Reciprocal table: ceil(2^RECIP_SHIFT / d) for divisors of two and up.
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 32;

    // Number of register stages from the input to the output register.
    localparam int NUM_STAGES = 6;

    // Values produced by the first stage.
    typedef struct packed {
        logic [CHAN_W-1:0] chroma;
        logic [SUM_W-1:0]  sum;
        logic [CHAN_W-1:0] den;
        logic [M_W-1:0]    pos;
        logic              grey;
    } t_front;

endpackage

`default_nettype wire

### rtl/rgb2hsl_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Pixel channel: one RGB word per handshake.
interface rgb2hsl_pixel_if;
    import rgb2hsl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: one HSL word per handshake.
interface rgb2hsl_result_if;
    import rgb2hsl_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [SUM_W-1:0] lightness_sum;
    logic             grey;

    modport source (output valid, output hue, output saturation, output lightness_sum,
                    output grey, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness_sum,
                    input grey, output ready);
endinterface

`default_nettype wire

### rtl/rgb2hsl_recip_rom.sv
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsl_recip_rom (
    input  wire logic [rgb2hsl_pkg::CHAN_W-1:0]  i_divisor,
    output logic      [rgb2hsl_pkg::RECIP_W-1:0] o_recip
);
    import rgb2hsl_pkg::*;

    localparam int DEPTH = 2 ** CHAN_W;

    logic [RECIP_W-1:0] w_table [DEPTH];

    // Rounded-up reciprocals, built at elaboration. Divisors zero and one
    // hold zero: a grey pixel has no quotient and division by one is bypassed.
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [63:0] DIV = (i < 2) ? 64'd1 : 64'(i);
        localparam logic [63:0] VAL = (i < 2) ? 64'd0 :
            ((64'd1 << RECIP_SHIFT) + DIV - 64'd1) / DIV;
        assign w_table[i] = VAL[RECIP_W-1:0];
    end

    assign o_recip = w_table[i_divisor];

endmodule

`default_nettype wire

### rtl/rgb2hsl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsl_front (
    input  wire logic [rgb2hsl_pkg::CHAN_W-1:0] i_red,
    input  wire logic [rgb2hsl_pkg::CHAN_W-1:0] i_green,
    input  wire logic [rgb2hsl_pkg::CHAN_W-1:0] i_blue,
    output rgb2hsl_pkg::t_front                 o_front
);
    import rgb2hsl_pkg::*;

    // One spare bit so that the sector sums wrap cleanly before truncation.
    localparam int MA_W = M_W + 1;

    logic              w_red_max;
    logic              w_green_max;
    logic [CHAN_W-1:0] w_max;
    logic [CHAN_W-1:0] w_min;
    logic [CHAN_W-1:0] w_chroma;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_den;
    logic [MA_W-1:0]   w_pos;

    // Largest component: red wins a tie, then green.
    assign w_red_max   = (i_red >= i_green) && (i_red >= i_blue);
    assign w_green_max = !w_red_max && (i_green >= i_blue);

    always_comb begin
        w_max = w_red_max ? i_red : (w_green_max ? i_green : i_blue);
        w_min = i_red;
        if (i_green < w_min) begin
            w_min = i_green;
        end
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
    end

    assign w_chroma = w_max - w_min;
    assign w_sum    = SUM_W'(w_max) + SUM_W'(w_min);

    // Saturation divisor: the distance of the sum from the nearer end.
    assign w_den = (w_sum > SUM_W'(CHAN_MAX)) ? (SUM_W'(SUM_MAX) - w_sum) : w_sum;

    // Position around the wheel in units of 60/chroma degree; always in 0 .. 6*chroma.
    always_comb begin
        if (w_red_max) begin
            w_pos = MA_W'(i_green) - MA_W'(i_blue);
            if (i_green < i_blue) begin
                w_pos = w_pos + MA_W'(SECTOR_COUNT) * MA_W'(w_chroma);
            end
        end else if (w_green_max) begin
            w_pos = MA_W'(i_blue) - MA_W'(i_red)
                  + MA_W'(GREEN_SECTOR_BASE) * MA_W'(w_chroma);
        end else begin
            w_pos = MA_W'(i_red) - MA_W'(i_green)
                  + MA_W'(BLUE_SECTOR_BASE) * MA_W'(w_chroma);
        end
    end

    assign o_front.chroma = w_chroma;
    assign o_front.sum    = w_sum;
    assign o_front.den    = w_den[CHAN_W-1:0];
    assign o_front.pos    = w_pos[M_W-1:0];
    assign o_front.grey   = (w_chroma == '0);

endmodule

`default_nettype wire

### rtl/rgb_to_hsl_converter_top.sv
// RGB to HSL converter, six register stages from input to output register.
// Throughput: one pixel per cycle while the output is ready; the depth comes
// from the reciprocal lookup, the whole-degree multiply, the remainder step
// and the fraction multiply.
// Stages hold their word while stalled and empty stages fill up behind a stall.
// Reset (synchronous, active low) clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_converter_top #(
    parameter int HUE_FRACTION_BITS        = rgb2hsl_pkg::HUE_FRACTION_BITS_DEF,
    parameter int SATURATION_FRACTION_BITS = rgb2hsl_pkg::SAT_FRACTION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rgb2hsl_pixel_if.sink    i_pixel,
    rgb2hsl_result_if.source o_result
);
    import rgb2hsl_pkg::*;

    localparam int HF        = HUE_FRACTION_BITS;
    localparam int SF        = SATURATION_FRACTION_BITS;
    localparam int HFW       = (HF == 0) ? 1 : HF;
    localparam int SN_W      = CHAN_W + SF;
    localparam int SQ_W      = SF + 1;
    localparam int Y_W       = CHAN_W + HF;
    localparam int HF_W      = Q_W + HF;
    localparam int HUE_EXT_W = (HF_W > HUE_W) ? HF_W : HUE_W;
    localparam int SAT_EXT_W = (SQ_W > SAT_W) ? SQ_W : SAT_W;

    // Stage valid bits and the per-stage load enables.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_take;

    // A stage loads when it is empty or the stage after it moves on.
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_take
        if (k == NUM_STAGES - 1) begin : g_last
            assign w_take[k] = !r_vld[k] || o_result.ready;
        end else begin : g_mid
            assign w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    assign n_vld = (w_take & {r_vld[NUM_STAGES-2:0], i_pixel.valid}) | (~w_take & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pixel.ready = w_take[0];

    // Stage 1: extremes, chroma, sum and wheel position.
    t_front n_s1_front;
    t_front r_s1_front;

    rgb2hsl_front u_front (
        .i_red   (i_pixel.red),
        .i_green (i_pixel.green),
        .i_blue  (i_pixel.blue),
        .o_front (n_s1_front)
    );

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            r_s1_front <= n_s1_front;
        end
    end

    // Stage 2: reciprocal lookups and the position scaled to degrees.
    logic [RECIP_W-1:0] n_s2_recip_c;
    logic [RECIP_W-1:0] n_s2_recip_d;
    logic [T_W-1:0]     n_s2_deg;
    logic [RECIP_W-1:0] r_s2_recip_c;
    logic [RECIP_W-1:0] r_s2_recip_d;
    logic [T_W-1:0]     r_s2_deg;
    logic [CHAN_W-1:0]  r_s2_chroma;
    logic               r_s2_c_one;
    logic               r_s2_d_one;
    logic [SUM_W-1:0]   r_s2_sum;
    logic               r_s2_grey;

    rgb2hsl_recip_rom u_recip_chroma (
        .i_divisor (r_s1_front.chroma),
        .o_recip   (n_s2_recip_c)
    );

    rgb2hsl_recip_rom u_recip_den (
        .i_divisor (r_s1_front.den),
        .o_recip   (n_s2_recip_d)
    );

    assign n_s2_deg = T_W'(DEG_PER_SECTOR) * T_W'(r_s1_front.pos);

    always_ff @(posedge i_clk) begin
        if (w_take[1]) begin
            r_s2_recip_c <= n_s2_recip_c;
            r_s2_recip_d <= n_s2_recip_d;
            r_s2_deg     <= n_s2_deg;
            r_s2_chroma  <= r_s1_front.chroma;
            r_s2_c_one   <= (r_s1_front.chroma == CHAN_W'(1));
            r_s2_d_one   <= (r_s1_front.den == CHAN_W'(1));
            r_s2_sum     <= r_s1_front.sum;
            r_s2_grey    <= r_s1_front.grey;
        end
    end

    // Stage 3: whole degrees and saturation by reciprocal multiply.
    logic [T_W+RECIP_W-1:0]  n_s3_prod_q;
    logic [SN_W-1:0]         n_s3_sat_num;
    logic [SN_W+RECIP_W-1:0] n_s3_prod_s;
    logic [Q_W-1:0]          n_s3_q;
    logic [SQ_W-1:0]         n_s3_sat;
    logic [Q_W-1:0]          r_s3_q;
    logic [SQ_W-1:0]         r_s3_sat;
    logic [T_W-1:0]          r_s3_deg;
    logic [RECIP_W-1:0]      r_s3_recip_c;
    logic [CHAN_W-1:0]       r_s3_chroma;
    logic [SUM_W-1:0]        r_s3_sum;
    logic                    r_s3_grey;

    assign n_s3_prod_q  = (T_W+RECIP_W)'(r_s2_deg) * (T_W+RECIP_W)'(r_s2_recip_c);
    assign n_s3_q       = r_s2_c_one ? r_s2_deg[Q_W-1:0] : n_s3_prod_q[RECIP_SHIFT +: Q_W];
    assign n_s3_sat_num = SN_W'(r_s2_chroma) << SF;
    assign n_s3_prod_s  = (SN_W+RECIP_W)'(n_s3_sat_num) * (SN_W+RECIP_W)'(r_s2_recip_d);
    assign n_s3_sat     = r_s2_d_one ? n_s3_sat_num[SQ_W-1:0]
                                     : n_s3_prod_s[RECIP_SHIFT +: SQ_W];

    always_ff @(posedge i_clk) begin
        if (w_take[2]) begin
            r_s3_q       <= n_s3_q;
            r_s3_sat     <= n_s3_sat;
            r_s3_deg     <= r_s2_deg;
            r_s3_recip_c <= r_s2_recip_c;
            r_s3_chroma  <= r_s2_chroma;
            r_s3_sum     <= r_s2_sum;
            r_s3_grey    <= r_s2_grey;
        end
    end

    // Stage 4: remainder of the whole-degree division.
    logic [T_W-1:0]     n_s4_qc;
    logic [T_W-1:0]     n_s4_diff;
    logic [CHAN_W-1:0]  r_s4_rem;
    logic [Q_W-1:0]     r_s4_q;
    logic [SQ_W-1:0]    r_s4_sat;
    logic [RECIP_W-1:0] r_s4_recip_c;
    logic [SUM_W-1:0]   r_s4_sum;
    logic               r_s4_grey;

    assign n_s4_qc   = T_W'(r_s3_q) * T_W'(r_s3_chroma);
    assign n_s4_diff = r_s3_deg - n_s4_qc;

    always_ff @(posedge i_clk) begin
        if (w_take[3]) begin
            r_s4_rem     <= n_s4_diff[CHAN_W-1:0];
            r_s4_q       <= r_s3_q;
            r_s4_sat     <= r_s3_sat;
            r_s4_recip_c <= r_s3_recip_c;
            r_s4_sum     <= r_s3_sum;
            r_s4_grey    <= r_s3_grey;
        end
    end

    // Stage 5: fraction of a degree from the remainder. With a chroma of one
    // the remainder is zero and the table entry is zero, so this stays zero.
    logic [Y_W-1:0]         n_s5_num;
    logic [Y_W+RECIP_W-1:0] n_s5_prod;
    logic [HFW-1:0]         r_s5_frac;
    logic [Q_W-1:0]         r_s5_q;
    logic [SQ_W-1:0]        r_s5_sat;
    logic [SUM_W-1:0]       r_s5_sum;
    logic                   r_s5_grey;

    assign n_s5_num  = Y_W'(r_s4_rem) << HF;
    assign n_s5_prod = (Y_W+RECIP_W)'(n_s5_num) * (Y_W+RECIP_W)'(r_s4_recip_c);

    always_ff @(posedge i_clk) begin
        if (w_take[4]) begin
            r_s5_frac <= n_s5_prod[RECIP_SHIFT +: HFW];
            r_s5_q    <= r_s4_q;
            r_s5_sat  <= r_s4_sat;
            r_s5_sum  <= r_s4_sum;
            r_s5_grey <= r_s4_grey;
        end
    end

    // Stage 6: output register; a grey pixel reports zero hue and saturation.
    logic [HF_W-1:0]      n_s6_hue_full;
    logic [HUE_EXT_W-1:0] n_s6_hue_ext;
    logic [SAT_EXT_W-1:0] n_s6_sat_ext;
    logic [HUE_W-1:0]     r_s6_hue;
    logic [SAT_W-1:0]     r_s6_sat;
    logic [SUM_W-1:0]     r_s6_sum;
    logic                 r_s6_grey;

    assign n_s6_hue_full = (HF_W'(r_s5_q) << HF) + HF_W'(r_s5_frac);
    assign n_s6_hue_ext  = HUE_EXT_W'(n_s6_hue_full);
    assign n_s6_sat_ext  = SAT_EXT_W'(r_s5_sat);

    always_ff @(posedge i_clk) begin
        if (w_take[5]) begin
            r_s6_hue  <= r_s5_grey ? '0 : n_s6_hue_ext[HUE_W-1:0];
            r_s6_sat  <= r_s5_grey ? '0 : n_s6_sat_ext[SAT_W-1:0];
            r_s6_sum  <= r_s5_sum;
            r_s6_grey <= r_s5_grey;
        end
    end

    assign o_result.valid         = r_vld[NUM_STAGES-1];
    assign o_result.hue           = r_s6_hue;
    assign o_result.saturation    = r_s6_sat;
    assign o_result.lightness_sum = r_s6_sum;
    assign o_result.grey          = r_s6_grey;

endmodule

`default_nettype wire
